[design/sle_pkg.sv]
// shared types and constants for the sequential list engine
// beat structs, command codes and the controller/datapath interface structs
// no dependencies
package sle_pkg;

  // default sizes handed to the top level parameters
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // command codes
  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_INSERT  = 3'd1;
  localparam logic [2:0] CMD_FIND    = 3'd2;
  localparam logic [2:0] CMD_REMOVE  = 3'd3;
  localparam logic [2:0] CMD_WRITE   = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;
  localparam logic [2:0] CMD_CLEAR   = 3'd6;

  // request beat
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic [3:0]         position;
  } req_t;

  // response beat
  typedef struct packed {
    logic               ok;
    logic [3:0]         found_index;
    logic signed [31:0] read_value;
    logic [4:0]         count;
  } rsp_t;

  // datapath operation selects
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC,
    PTR_COUNT
  } ptr_op_t;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_P1,
    RD_PTR_M1,
    RD_POS
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_PTR,
    WA_POS,
    WA_COUNT
  } wa_sel_t;

  typedef enum logic {
    WD_VAL,
    WD_RDATA
  } wd_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_ZERO
  } cnt_op_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    ptr_op_t ptr_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    cnt_op_t cnt_op;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic pos_le_cnt;
    logic pos_lt_cnt;
    logic match;
    logic ptr_last;
    logic ptr_at_pos;
  } stat_t;

  // result strobe and flags from controller to the output stage
  typedef struct packed {
    logic capture;
    logic ok;
    logic found;
    logic rd;
  } res_t;

endpackage

[design/sle_dpath.sv]
// datapath of the sequential list engine: entry memory, count, scan pointer
// and the compares that feed the controller
// depends on sle_pkg
module sle_dpath #(
  parameter int DEPTH      = sle_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sle_pkg::ctrl_t        ctrl,
  input  logic signed [31:0]    value,
  input  logic [3:0]            position,
  output sle_pkg::stat_t        stat,
  output logic [DATA_WIDTH-1:0] rdata,
  output logic [AW-1:0]         ptr,
  output logic [CW-1:0]         count
);

  localparam int PW = (CW > 4) ? CW : 4;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] val_q;
  logic [3:0]            pos_q;
  logic [63:0]           val_ext;
  logic [PW-1:0]         pos_ext;
  logic [PW-1:0]         count_ext;
  logic [AW-1:0]         pos_addr;
  logic [AW-1:0]         ra;
  logic [AW-1:0]         wa;
  logic [DATA_WIDTH-1:0] wd;

  // operand latch, value kept in its low bits after sign extension
  assign val_ext = 64'(value);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      val_q <= val_ext[DATA_WIDTH-1:0];
      pos_q <= position;
    end
  end

  assign pos_ext   = PW'(pos_q);
  assign count_ext = PW'(count);
  assign pos_addr  = pos_ext[AW-1:0];

  // scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      case (ctrl.ptr_op)
        sle_pkg::PTR_ZERO:  ptr <= '0;
        sle_pkg::PTR_INC:   ptr <= ptr + AW'(1);
        sle_pkg::PTR_DEC:   ptr <= ptr - AW'(1);
        sle_pkg::PTR_COUNT: ptr <= count[AW-1:0];
        default:            ptr <= ptr;
      endcase
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (ctrl.cnt_op)
        sle_pkg::CNT_INC:  count <= count + CW'(1);
        sle_pkg::CNT_DEC:  count <= count - CW'(1);
        sle_pkg::CNT_ZERO: count <= '0;
        default:           count <= count;
      endcase
    end
  end

  // address and data selection
  always_comb begin
    case (ctrl.rd_sel)
      sle_pkg::RD_PTR_P1: ra = ptr + AW'(1);
      sle_pkg::RD_PTR_M1: ra = ptr - AW'(1);
      sle_pkg::RD_POS:    ra = pos_addr;
      default:            ra = ptr;
    endcase
    case (ctrl.wa_sel)
      sle_pkg::WA_POS:   wa = pos_addr;
      sle_pkg::WA_COUNT: wa = count[AW-1:0];
      default:           wa = ptr;
    endcase
    case (ctrl.wd_sel)
      sle_pkg::WD_RDATA: wd = rdata;
      default:           wd = val_q;
    endcase
  end

  // entry memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wa] <= wd;
    end
    if (ctrl.rd_en) begin
      rdata <= mem[ra];
    end
  end

  // status compares
  assign stat.full       = (count == CW'(DEPTH));
  assign stat.cnt_zero   = (count == '0);
  assign stat.pos_le_cnt = (pos_ext <= count_ext);
  assign stat.pos_lt_cnt = (pos_ext < count_ext);
  assign stat.match      = (rdata == val_q);
  assign stat.ptr_last   = ((CW'(ptr) + CW'(1)) >= count);
  assign stat.ptr_at_pos = (PW'(ptr) == pos_ext);

endmodule

[design/sle_ctrl.sv]
// controller of the sequential list engine: one-hot sequencer that decodes
// a command and steps the datapath through scans and shifts
// depends on sle_pkg
module sle_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic [2:0]     req_cmd,
  input  logic           out_free,
  input  sle_pkg::stat_t stat,
  output logic           req_ready,
  output sle_pkg::ctrl_t ctrl,
  output sle_pkg::res_t  res
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_INS_CHK = 9'b000000100,
    S_INS_WR  = 9'b000001000,
    S_SCAN    = 9'b000010000,
    S_REM_CHK = 9'b000100000,
    S_REM_WR  = 9'b001000000,
    S_RDWAIT  = 9'b010000000,
    S_POST    = 9'b100000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] cmd_q;
  logic       ok_q;
  logic       found_q;
  logic       rd_q;
  logic       fin;
  logic       fin_ok;
  logic       fin_found;
  logic       fin_rd;

  // sequencer
  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.ptr_op = sle_pkg::PTR_HOLD;
    ctrl.rd_en  = 1'b0;
    ctrl.rd_sel = sle_pkg::RD_PTR;
    ctrl.wr_en  = 1'b0;
    ctrl.wa_sel = sle_pkg::WA_PTR;
    ctrl.wd_sel = sle_pkg::WD_VAL;
    ctrl.cnt_op = sle_pkg::CNT_HOLD;
    fin         = 1'b0;
    fin_ok      = 1'b0;
    fin_found   = 1'b0;
    fin_rd      = 1'b0;
    res.capture = 1'b0;
    res.ok      = ok_q;
    res.found   = found_q;
    res.rd      = rd_q;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctrl.load   = 1'b1;
          ctrl.ptr_op = sle_pkg::PTR_ZERO;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (cmd_q) inside
          sle_pkg::CMD_APPEND: begin
            fin = 1'b1;
            if (!stat.full) begin
              ctrl.wr_en  = 1'b1;
              ctrl.wa_sel = sle_pkg::WA_COUNT;
              ctrl.cnt_op = sle_pkg::CNT_INC;
              fin_ok      = 1'b1;
            end
          end
          sle_pkg::CMD_INSERT: begin
            if (!stat.full && stat.pos_le_cnt) begin
              ctrl.ptr_op = sle_pkg::PTR_COUNT;
              state_next  = S_INS_CHK;
            end else begin
              fin = 1'b1;
            end
          end
          sle_pkg::CMD_FIND, sle_pkg::CMD_REMOVE: begin
            if (stat.cnt_zero) begin
              fin = 1'b1;
            end else begin
              ctrl.rd_en  = 1'b1;
              ctrl.rd_sel = sle_pkg::RD_PTR;
              state_next  = S_SCAN;
            end
          end
          sle_pkg::CMD_WRITE: begin
            fin = 1'b1;
            if (stat.pos_lt_cnt) begin
              ctrl.wr_en  = 1'b1;
              ctrl.wa_sel = sle_pkg::WA_POS;
              fin_ok      = 1'b1;
            end
          end
          sle_pkg::CMD_READ: begin
            if (stat.pos_lt_cnt) begin
              ctrl.rd_en  = 1'b1;
              ctrl.rd_sel = sle_pkg::RD_POS;
              state_next  = S_RDWAIT;
            end else begin
              fin = 1'b1;
            end
          end
          sle_pkg::CMD_CLEAR: begin
            fin         = 1'b1;
            fin_ok      = 1'b1;
            ctrl.cnt_op = sle_pkg::CNT_ZERO;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      // insert: move entries up one from the end down to the position
      S_INS_CHK: begin
        if (stat.ptr_at_pos) begin
          ctrl.wr_en  = 1'b1;
          ctrl.wa_sel = sle_pkg::WA_POS;
          ctrl.cnt_op = sle_pkg::CNT_INC;
          fin         = 1'b1;
          fin_ok      = 1'b1;
        end else begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = sle_pkg::RD_PTR_M1;
          state_next  = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wa_sel = sle_pkg::WA_PTR;
        ctrl.wd_sel = sle_pkg::WD_RDATA;
        ctrl.ptr_op = sle_pkg::PTR_DEC;
        state_next  = S_INS_CHK;
      end
      // linear search, one entry a cycle
      S_SCAN: begin
        if (stat.match) begin
          if (cmd_q == sle_pkg::CMD_FIND) begin
            fin       = 1'b1;
            fin_ok    = 1'b1;
            fin_found = 1'b1;
          end else begin
            state_next = S_REM_CHK;
          end
        end else if (stat.ptr_last) begin
          fin = 1'b1;
        end else begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = sle_pkg::RD_PTR_P1;
          ctrl.ptr_op = sle_pkg::PTR_INC;
        end
      end
      // remove: move later entries down one
      S_REM_CHK: begin
        if (stat.ptr_last) begin
          ctrl.cnt_op = sle_pkg::CNT_DEC;
          fin         = 1'b1;
          fin_ok      = 1'b1;
        end else begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = sle_pkg::RD_PTR_P1;
          state_next  = S_REM_WR;
        end
      end
      S_REM_WR: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wa_sel = sle_pkg::WA_PTR;
        ctrl.wd_sel = sle_pkg::WD_RDATA;
        ctrl.ptr_op = sle_pkg::PTR_INC;
        state_next  = S_REM_CHK;
      end
      S_RDWAIT: begin
        fin    = 1'b1;
        fin_ok = 1'b1;
        fin_rd = 1'b1;
      end
      // count has settled, hand the result to the output register
      S_POST: begin
        if (out_free) begin
          res.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) begin
      state_next = S_POST;
    end
  end

  // state, command and result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cmd_q   <= sle_pkg::CMD_APPEND;
      ok_q    <= 1'b0;
      found_q <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && req_valid) begin
        cmd_q <= req_cmd;
      end
      if (fin) begin
        ok_q    <= fin_ok;
        found_q <= fin_found;
        rd_q    <= fin_rd;
      end
    end
  end

endmodule

[design/sequential_list_engine.sv]
// Sequential list engine: an ordered list of up to DEPTH signed entries held
// in a memory with one write port and one registered read port, with
// append, insert, find, remove, overwrite, read and clear commands, one
// response beat per request beat. A request is taken only while the
// sequencer is idle; a finished response waits in an output register so the
// next request can be taken meanwhile. Insert and remove shift entries
// through the memory port, which moves one entry per read/write pair, and
// find scans the list from index 0; a result that finds the output register
// still full holds the sequencer until that response is taken. No clearing
// pass is needed after reset.
// depends on sle_pkg, sle_ctrl, sle_dpath
module sequential_list_engine #(
  parameter int DEPTH      = sle_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sle_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sle_pkg::rsp_t rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sle_pkg::ctrl_t        ctrl;
  sle_pkg::stat_t        stat;
  sle_pkg::res_t         res;
  logic [DATA_WIDTH-1:0] rdata;
  logic [AW-1:0]         ptr;
  logic [CW-1:0]         count;
  logic [63:0]           rdata_ext;
  logic                  out_free;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .out_free  (out_free),
    .stat      (stat),
    .req_ready (req_ready),
    .ctrl      (ctrl),
    .res       (res)
  );

  sle_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .value    (req.value),
    .position (req.position),
    .stat     (stat),
    .rdata    (rdata),
    .ptr      (ptr),
    .count    (count)
  );

  // entry sign extended out to the response width
  assign rdata_ext = 64'($signed(rdata));
  assign out_free  = !rsp_valid || rsp_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res.capture) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.capture) begin
      rsp.ok          <= res.ok;
      rsp.found_index <= res.found ? 4'(ptr) : 4'd0;
      rsp.read_value  <= res.rd ? rdata_ext[31:0] : 32'd0;
      rsp.count       <= 5'(count);
    end
  end

  // busy straight after a request beat
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is still at work");

  // results only go into a free output register
  a_capture_free: assert property (@(posedge clk) disable iff (rst)
    res.capture |-> (!rsp_valid || rsp_ready))
    else $error("response overwritten before it was taken");

  // the list never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // a failed command reports neither an index nor a value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> (rsp.found_index == 4'd0) && (rsp.read_value == 32'd0))
    else $error("failed response carries data");

endmodule

[sim/sle_list_check.sv]
// list checker: mirrors the list, predicts each response beat and compares
// depends on sle_pkg; placed beside the engine in sequential_list_engine_tb
`timescale 1ns / 1ps

module sle_list_check
  import sle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   rsp_owed
);

  localparam int DEPTH = DEPTH_DEF;

  // mirrored list contents and length
  logic signed [31:0] mirror_entries [DEPTH];
  logic [4:0]         mirror_len;

  // responses owed by the engine, oldest first
  rsp_t due_rsps [$];
  int   mismatches = 0;

  // apply one command to the mirror and return the response it should give
  function automatic rsp_t apply_list_cmd(input req_t b);
    rsp_t r;
    int   hit;
    int   j;
    r   = '0;
    hit = -1;
    case (b.cmd)
      CMD_APPEND: begin
        if (mirror_len < DEPTH) begin
          mirror_entries[mirror_len] = b.value;
          mirror_len = mirror_len + 1'b1;
          r.ok = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (mirror_len < DEPTH && b.position <= mirror_len) begin
          for (j = mirror_len; j > b.position; j--)
            mirror_entries[j] = mirror_entries[j - 1];
          mirror_entries[b.position] = b.value;
          mirror_len = mirror_len + 1'b1;
          r.ok = 1'b1;
        end
      end
      CMD_FIND, CMD_REMOVE: begin
        // first match wins
        for (j = 0; j < mirror_len; j++)
          if (hit < 0 && mirror_entries[j] == b.value) hit = j;
        if (hit >= 0) begin
          r.ok = 1'b1;
          if (b.cmd == CMD_FIND) begin
            r.found_index = 4'(hit);
          end else begin
            for (j = hit; j + 1 < mirror_len; j++)
              mirror_entries[j] = mirror_entries[j + 1];
            mirror_len = mirror_len - 1'b1;
          end
        end
      end
      CMD_WRITE: begin
        if (b.position < mirror_len) begin
          mirror_entries[b.position] = b.value;
          r.ok = 1'b1;
        end
      end
      CMD_READ: begin
        if (b.position < mirror_len) begin
          r.read_value = mirror_entries[b.position];
          r.ok = 1'b1;
        end
      end
      CMD_CLEAR: begin
        mirror_len = '0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = mirror_len;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // watch both channels; responses are checked before a same-edge request is mirrored
  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      mirror_len = '0;
      due_rsps.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_rsps.size() == 0) begin
          $error("response beat with no request outstanding");
          mismatches++;
        end else begin
          want = due_rsps.pop_front();
          check_field("ok", want.ok, rsp.ok);
          check_field("found_index", want.found_index, rsp.found_index);
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("count", want.count, rsp.count);
        end
      end
      if (req_valid && req_ready) due_rsps.push_back(apply_list_cmd(req));
    end
    rsp_owed   <= due_rsps.size();
    fail_count <= mismatches;
  end

endmodule

[sim/sequential_list_engine_tb.sv]
// top of the sequential list engine bench: clock, reset, request stimulus,
// response back-pressure and the verdict; depends on sle_pkg, the engine
// and sle_list_check
`timescale 1ns / 1ps

module sequential_list_engine_tb;

  import sle_pkg::*;

  localparam logic [2:0] CMD_UNUSED   = 3'd7;
  localparam int RANDOM_BEATS   = 950;
  localparam int BATCH_BEATS    = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fail_count;
  int rsp_owed;
  int idle_cycles = 0;

  // recently stored values, reused so that finds and removes often hit
  logic [31:0] value_pool [8] = '{default: '0};
  logic [2:0]  pool_wr = '0;
  bit          calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sequential_list_engine dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  sle_list_check list_check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .fail_count(fail_count),
    .rsp_owed  (rsp_owed)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return value_pool[$urandom_range(0, 7)];
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0:       return 32'h0000_0000;
        1:       return 32'hffff_ffff;
        2:       return 32'h7fff_ffff;
        default: return 32'h8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_cmd(input mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 45) return CMD_APPEND;
        if (r < 70) return CMD_INSERT;
        if (r < 78) return CMD_FIND;
        if (r < 85) return CMD_WRITE;
        if (r < 93) return CMD_READ;
        if (r < 98) return CMD_REMOVE;
        return CMD_UNUSED;
      end
      MIX_SHRINK: begin
        if (r < 35) return CMD_REMOVE;
        if (r < 50) return CMD_FIND;
        if (r < 62) return CMD_READ;
        if (r < 72) return CMD_WRITE;
        if (r < 82) return CMD_APPEND;
        if (r < 90) return CMD_INSERT;
        if (r < 95) return CMD_CLEAR;
        return CMD_UNUSED;
      end
      default: begin
        if (r < 20) return CMD_APPEND;
        if (r < 36) return CMD_INSERT;
        if (r < 52) return CMD_FIND;
        if (r < 64) return CMD_REMOVE;
        if (r < 76) return CMD_WRITE;
        if (r < 92) return CMD_READ;
        if (r < 94) return CMD_CLEAR;
        if (r < 96) return CMD_UNUSED;
        return CMD_APPEND;
      end
    endcase
  endfunction

  // present one request beat and hold it until it is taken
  task automatic send_beat(input logic [2:0] op, input logic [31:0] v,
                           input logic [3:0] pos);
    req_t b;
    int   gap;
    b.cmd      = op;
    b.value    = v;
    b.position = pos;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= b;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    if (op == CMD_APPEND || op == CMD_INSERT || op == CMD_WRITE) begin
      value_pool[pool_wr] = v;
      pool_wr++;
    end
  endtask

  // response back-pressure: short bursts and stalls, now and then a long clean run
  initial begin : rsp_stalls
    int run;
    int stall;
    int r;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 99) < 10) ? $urandom_range(40, 160)
                                         : $urandom_range(1, 6);
      r = $urandom_range(0, 99);
      if (r < 40)      stall = $urandom_range(1, 2);
      else if (r < 85) stall = $urandom_range(3, 6);
      else             stall = $urandom_range(8, 30);
      rsp_ready <= 1'b1;
      repeat (run) @(posedge clk);
      rsp_ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int   n;
    int   k;
    mix_t mix;
    logic [3:0] pos;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty list and unknown command
    send_beat(CMD_READ, 32'h0, 4'd0);
    send_beat(CMD_REMOVE, 32'h0, 4'd0);
    send_beat(CMD_UNUSED, 32'hffff_ffff, 4'hf);
    // extremes, insert at the head and at the end, out-of-range positions
    send_beat(CMD_APPEND, 32'h7fff_ffff, 4'd0);
    send_beat(CMD_APPEND, 32'h8000_0000, 4'hf);
    send_beat(CMD_INSERT, 32'hffff_ffff, 4'd0);
    send_beat(CMD_INSERT, 32'h0, 4'd3);
    send_beat(CMD_INSERT, 32'h5, 4'd5);
    send_beat(CMD_WRITE, 32'h6, 4'd4);
    send_beat(CMD_WRITE, 32'h55aa_55aa, 4'd1);
    send_beat(CMD_READ, 32'h0, 4'd3);
    send_beat(CMD_READ, 32'h0, 4'd4);
    send_beat(CMD_FIND, 32'h8000_0000, 4'd0);
    send_beat(CMD_FIND, 32'h0000_3039, 4'd0);
    send_beat(CMD_REMOVE, 32'hffff_ffff, 4'd0);
    // fill to the top; the first of these repeats a zero already held
    for (k = 0; k < 13; k++) send_beat(CMD_APPEND, 32'h0100_0001 * k, 4'd0);
    send_beat(CMD_APPEND, 32'h1, 4'd0);
    send_beat(CMD_INSERT, 32'h1, 4'd0);
    send_beat(CMD_READ, 32'h0, 4'hf);
    send_beat(CMD_FIND, 32'h0c00_000c, 4'd0);
    send_beat(CMD_REMOVE, 32'h0, 4'd0);
    send_beat(CMD_CLEAR, 32'h0, 4'd0);
    send_beat(CMD_FIND, 32'h0, 4'd0);

    // random batches, each leaning towards growth, shrinkage or an even mix
    mix = MIX_GROW;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % BATCH_BEATS == 0) begin
        case ($urandom_range(0, 3))
          0:       mix = MIX_GROW;
          1:       mix = MIX_SHRINK;
          default: mix = MIX_EVEN;
        endcase
        calm = ($urandom_range(0, 3) == 0);
      end
      pos = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 7)) : 4'($urandom);
      send_beat(pick_cmd(mix), pick_value(), pos);
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    // drain outstanding responses, then allow stray beats to show
    do @(posedge clk); while (rsp_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sequential_list_engine.f]
design/sle_pkg.sv
design/sle_dpath.sv
design/sle_ctrl.sv
design/sequential_list_engine.sv
sim/sle_list_check.sv
sim/sequential_list_engine_tb.sv
